>>> rtl/cde_pkg.sv
// Shared types and constants for the civil date to epoch seconds converter.
package cde_pkg;

	localparam int unsigned YearMin = 1970;
	localparam int unsigned YearMax = 2999;
	localparam int unsigned YearBase = 1900;

	// Reciprocal for division by 100 on values below 2^15: (x * 5243) >> 19.
	localparam int unsigned Recip100 = 5243;
	localparam int unsigned Recip100Shift = 19;
	// Reciprocal for division by 7 on values below 2^19: (x * 4793491) >> 25.
	localparam int unsigned Recip7 = 4793491;
	localparam int unsigned Recip7Shift = 25;

	// Cumulative days before each month of a common year.
	localparam logic [8:0] MonthStart [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Clamped and partly reduced request after the first stage.
	typedef struct packed {
		logic [11:0] year;
		logic [10:0] ty;
		logic [10:0] leap_ref;
		logic        late_month;
		logic [8:0]  yday_base;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cde_prep_t;

	// Day count and day of year after the day stages.
	typedef struct packed {
		logic [18:0] days;
		logic [8:0]  yday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cde_day_t;

endpackage

>>> rtl/cde_prep.sv
// First stage: clamp the fields, look up the month offset, form the leap reference year.
module cde_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [11:0]       year,
	input  logic [3:0]        month,
	input  logic [4:0]        day,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [5:0]        second,
	output logic              out_valid,
	output cde_pkg::cde_prep_t out_data
);

	logic [11:0] year_c;
	logic [3:0]  month_c;
	logic [4:0]  day_c;
	logic [3:0]  mi;
	logic [10:0] ty;
	cde_pkg::cde_prep_t prep;
	logic        v_s1;
	cde_pkg::cde_prep_t data_s1;

	always_comb begin
		if (year < 12'(cde_pkg::YearMin)) begin
			year_c = 12'(cde_pkg::YearMin);
		end else if (year > 12'(cde_pkg::YearMax)) begin
			year_c = 12'(cde_pkg::YearMax);
		end else begin
			year_c = year;
		end
		if (month == 4'd0) begin
			month_c = 4'd1;
		end else if (month > 4'd12) begin
			month_c = 4'd12;
		end else begin
			month_c = month;
		end
		day_c = (day == 5'd0) ? 5'd1 : day;
		mi = month_c - 4'd1;
		ty = 11'(year_c - 12'(cde_pkg::YearBase));

		prep.year       = year_c;
		prep.ty         = ty;
		prep.late_month = (mi > 4'd1);
		prep.leap_ref   = prep.late_month ? ty + 11'd1 : ty;
		prep.yday_base  = cde_pkg::MonthStart[mi] + 9'(day_c) - 9'd1;
		prep.hour       = (hour > 5'd23) ? 5'd23 : hour;
		prep.minute     = (minute > 6'd59) ? 6'd59 : minute;
		prep.second     = (second > 6'd59) ? 6'd59 : second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= prep;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = data_s1;

endmodule

>>> rtl/cde_days.sv
// Second and third stages: leap-day counts and the day count since 1970-01-01.
module cde_days (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  cde_pkg::cde_prep_t in_data,
	output logic               out_valid,
	output cde_pkg::cde_day_t  out_data
);

	// Stage 2: constant multiplies for year length and the divisions.
	logic        v_s2;
	logic [18:0] y365_s2;
	logic [8:0]  q4_s2;
	logic [22:0] p100_s2;
	logic [22:0] p400_s2;
	logic [23:0] py_s2;
	logic [11:0] year_s2;
	logic        late_s2;
	logic [8:0]  ybase_s2;
	logic [4:0]  hour_s2;
	logic [5:0]  minute_s2;
	logic [5:0]  second_s2;

	// Stage 3 combinational terms.
	logic [3:0]  q100;
	logic [1:0]  q400;
	logic [4:0]  qy;
	logic [11:0] yrem_w;
	logic [6:0]  yrem;
	logic        leap;
	logic [19:0] days_w;
	cde_pkg::cde_day_t nxt;

	logic        v_s3;
	cde_pkg::cde_day_t data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y365_s2   <= 19'(19'(in_data.ty - 11'd70) * 19'd365);
			q4_s2     <= 9'((in_data.leap_ref - 11'd69) >> 2);
			p100_s2   <= 23'(in_data.leap_ref - 11'd1) * 23'(cde_pkg::Recip100);
			p400_s2   <= 23'(in_data.leap_ref + 11'd299) * 23'(cde_pkg::Recip100);
			py_s2     <= 24'(in_data.year) * 24'(cde_pkg::Recip100);
			year_s2   <= in_data.year;
			late_s2   <= in_data.late_month;
			ybase_s2  <= in_data.yday_base;
			hour_s2   <= in_data.hour;
			minute_s2 <= in_data.minute;
			second_s2 <= in_data.second;
		end
	end

	always_comb begin
		q100   = p100_s2[22:19];
		// Divide by 400 as the divide-by-100 reciprocal with two more bits of shift.
		q400   = p400_s2[22:21];
		qy     = py_s2[23:19];
		yrem_w = year_s2 - 12'(12'(qy) * 12'd100);
		yrem   = yrem_w[6:0];
		// Divisible by 400 when the century remainder is zero and the century count is a multiple of 4.
		leap   = ((year_s2[1:0] == 2'd0) && (yrem != 7'd0)) ||
		         ((yrem == 7'd0) && (qy[1:0] == 2'd0));
		days_w = 20'(y365_s2) + 20'(ybase_s2) + 20'(q4_s2) - 20'(q100) + 20'(q400);

		nxt.days   = days_w[18:0];
		nxt.yday   = ybase_s2 + 9'(leap & late_s2);
		nxt.hour   = hour_s2;
		nxt.minute = minute_s2;
		nxt.second = second_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

>>> rtl/cde_scale.sv
// Stages four to six: scale days to seconds and reduce the day count modulo 7.
module cde_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cde_pkg::cde_day_t in_data,
	output logic              out_valid,
	output logic [34:0]       epoch_seconds,
	output logic [8:0]        day_of_year,
	output logic [2:0]        weekday
);

	logic        v_s4;
	logic [23:0] hours_s4;
	logic [18:0] wx_s4;
	logic [41:0] wp_s4;
	logic [8:0]  yday_s4;
	logic [5:0]  minute_s4;
	logic [5:0]  second_s4;

	logic        v_s5;
	logic [29:0] mins_s5;
	logic [2:0]  wday_s5;
	logic [8:0]  yday_s5;
	logic [5:0]  second_s5;

	logic        v_s6;
	logic [34:0] secs_s6;
	logic [2:0]  wday_s6;
	logic [8:0]  yday_s6;

	logic [16:0] q7;
	logic [19:0] wrem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		q7   = wp_s4[41:25];
		wrem = 20'(wx_s4) - 20'(20'(q7) * 20'd7);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// 1970-01-01 was a Thursday.
			hours_s4  <= 24'(in_data.hour) + 24'(in_data.days) * 24'd24;
			wx_s4     <= in_data.days + 19'd4;
			wp_s4     <= 42'(in_data.days + 19'd4) * 42'(cde_pkg::Recip7);
			yday_s4   <= in_data.yday;
			minute_s4 <= in_data.minute;
			second_s4 <= in_data.second;

			mins_s5   <= 30'(minute_s4) + 30'(hours_s4) * 30'd60;
			wday_s5   <= wrem[2:0];
			yday_s5   <= yday_s4;
			second_s5 <= second_s4;

			secs_s6   <= 35'(second_s5) + 35'(mins_s5) * 35'd60;
			wday_s6   <= wday_s5;
			yday_s6   <= yday_s5;
		end
	end

	assign out_valid     = v_s6;
	assign epoch_seconds = secs_s6;
	assign day_of_year   = yday_s6;
	assign weekday       = wday_s6;

endmodule

>>> rtl/civil_date_to_epoch_seconds_top.sv
// Top level of the Gregorian date and time to Unix epoch seconds converter.
// Converts one UTC date and time request per cycle into epoch seconds, the zero-based day of the
// year and the weekday (0 is Sunday). The six-stage pipeline takes a new request every cycle
// while it is not stalled; out-of-range fields are clamped to their limits and a day past
// the month end runs on into the next month. When the result register is full and not taken, the
// whole pipeline holds, so s_tready drops only while m_tvalid is high and m_tready is low.
module civil_date_to_epoch_seconds_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // year[11:0], month[15:12], day[20:16], hour[25:21],
	                              // minute[31:26], second[37:32], zero[39:38]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // epoch_seconds[34:0], day_of_year[43:35], weekday[46:44],
	                              // zero[47]
);

	logic               en;
	logic               prep_valid;
	cde_pkg::cde_prep_t prep_data;
	logic               day_valid;
	cde_pkg::cde_day_t  day_data;
	logic [34:0]        epoch_seconds;
	logic [8:0]         day_of_year;
	logic [2:0]         weekday;

	// Advance the pipeline unless a finished result is stuck at the output.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	cde_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.year      (s_tdata[11:0]),
		.month     (s_tdata[15:12]),
		.day       (s_tdata[20:16]),
		.hour      (s_tdata[25:21]),
		.minute    (s_tdata[31:26]),
		.second    (s_tdata[37:32]),
		.out_valid (prep_valid),
		.out_data  (prep_data)
	);

	cde_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_valid),
		.in_data   (prep_data),
		.out_valid (day_valid),
		.out_data  (day_data)
	);

	cde_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (day_valid),
		.in_data       (day_data),
		.out_valid     (m_tvalid),
		.epoch_seconds (epoch_seconds),
		.day_of_year   (day_of_year),
		.weekday       (weekday)
	);

	assign m_tdata = {1'b0, weekday, day_of_year, epoch_seconds};

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[46:44] != 3'd7))
		else $error("weekday out of range");

	a_yday_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[43:35] <= 9'd365))
		else $error("day of year out of range");

	a_epoch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:0] <= 35'd32503679999))
		else $error("epoch seconds beyond year 2999");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(day_valid) && $stable(prep_valid))
		else $error("pipeline moved during a stall");

endmodule
